>>> src/det_pkg.sv
// Shared constants and types for the difference edge threshold block.
`default_nettype none

package det_pkg;

  // Line store depth and the counter widths that follow from it.
  localparam int MAX_WIDTH  = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = 12;

  // Register field widths.
  localparam int THRESH_W = 9;
  localparam int FWIDTH_W = 12;
  localparam int FHEIGHT_W = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  localparam logic [7:0] FLAT_VALUE = 8'd255;
  localparam logic [7:0] EDGE_VALUE = 8'd0;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_THRESHOLD    = 2'd0;
  localparam cfg_idx_t CFG_FRAME_WIDTH  = 2'd1;
  localparam cfg_idx_t CFG_FRAME_HEIGHT = 2'd2;

  // Item held in the compute stage while its results drain.
  typedef struct packed {
    logic [7:0]       pixel;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             has_top;
    logic             has_right;
    logic             last_row;
  } stage_t;

endpackage

`default_nettype wire

>>> src/difference_edge_threshold.sv
// Top level: streaming first-difference edge detector with an L1 threshold.
//
// Pixels arrive in raster order on the input channel (in_valid, in_stall,
// pixel); a beat is taken on a rising edge with in_valid high and in_stall
// low. Results leave on the output channel (out_valid, out_stall, value,
// out_row, out_col, last_of_run) under the same rule. Registers are written
// through the configuration channel (cfg_valid, cfg_ready, cfg_index,
// cfg_data); cfg_ready is always high, so every write is taken as soon as offered.
//
// Each accepted pixel reads the line store at its own column and the column
// to its right in the cycle it is taken, and writes itself back to its own
// column. The gradient and threshold are formed in the next cycle, and the
// first result moves into the output register once that register is free.
// Throughput is one pixel per clock while each pixel causes at most one
// result and the output is not stalled. A last-row pixel below row 0 has two
// results and holds the input, since the output register moves one per beat.
// A stall on the output holds the output register; the compute stage keeps
// its item, and in_stall rises once that stage cannot hand off its results.
// Reset empties both stages, zeroes the row and column counters and loads
// the register defaults (threshold 0, 640 by 480). The line store is not
// cleared: the first row of each frame only fills it.
`default_nettype none

module difference_edge_threshold (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Pixel input channel.
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     pixel,
  // Result output channel.
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [7:0]                          value,
  output logic [det_pkg::ROW_W-1:0]           out_row,
  output logic [det_pkg::COL_W-1:0]           out_col,
  output logic                                last_of_run,
  // Configuration write channel.
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire det_pkg::cfg_idx_t              cfg_index,
  input  wire logic [det_pkg::CFG_DATA_W-1:0] cfg_data
);
  import det_pkg::*;

  // Configuration registers.
  logic [THRESH_W-1:0]  threshold;
  logic [FWIDTH_W-1:0]  frame_width;
  logic [FHEIGHT_W-1:0] frame_height;

  // Raster position of the next pixel.
  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_count_next;
  logic [ROW_W-1:0] row_count_next;

  // Line store with its registered read ports.
  logic [7:0] line_mem [MAX_WIDTH];
  logic [7:0] up_q;
  logic [7:0] right_q;

  // Compute stage.
  logic   s1_valid;
  logic   s1_second;
  stage_t s1;
  stage_t s1_next;

  logic in_accept;
  logic cfg_accept;

  // Effective frame size after clamping.
  logic [FWIDTH_W-1:0]  w_eff;
  logic [FHEIGHT_W-1:0] h_eff;
  logic                 restart;
  logic [COL_W-1:0]     cur_col;
  logic [ROW_W-1:0]     cur_row;
  logic [FWIDTH_W-1:0]  col_inc;
  logic [FHEIGHT_W-1:0] row_inc;

  // Result selection in the compute stage.
  logic [7:0]          diff_right;
  logic [7:0]          diff_down;
  logic [THRESH_W-1:0] grad;
  logic [7:0]          top_value;
  logic                emit_top;
  logic                has_result;
  logic [7:0]          res_value;
  logic [ROW_W-1:0]    res_row;
  logic                res_last;
  logic                out_free;
  logic                s1_emit;
  logic                s1_done;

  assign cfg_ready  = 1'b1;
  assign cfg_accept = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= '0;
      frame_width  <= FWIDTH_W'(640);
      frame_height <= FHEIGHT_W'(480);
    end else if (cfg_accept) begin
      case (cfg_index)
        CFG_THRESHOLD:    threshold    <= cfg_data[THRESH_W-1:0];
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data[FWIDTH_W-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_data[FHEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero size counts as one; sizes beyond the store or the row range clamp.
  always_comb begin
    if (frame_width == '0) begin
      w_eff = FWIDTH_W'(1);
    end else if (frame_width > FWIDTH_W'(MAX_WIDTH)) begin
      w_eff = FWIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    if (frame_height == '0) begin
      h_eff = FHEIGHT_W'(1);
    end else if (frame_height > FHEIGHT_W'(MAX_HEIGHT)) begin
      h_eff = FHEIGHT_W'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
  end

  // If the frame shrank under the counters, this pixel starts a new frame.
  always_comb begin
    restart = (FWIDTH_W'(col_count) >= w_eff) || (FHEIGHT_W'(row_count) >= h_eff);
    cur_col = restart ? '0 : col_count;
    cur_row = restart ? '0 : row_count;
    col_inc = FWIDTH_W'(cur_col) + FWIDTH_W'(1);
    row_inc = FHEIGHT_W'(cur_row) + FHEIGHT_W'(1);

    if (col_inc >= w_eff) begin
      col_count_next = '0;
      row_count_next = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_count_next = col_inc[COL_W-1:0];
      row_count_next = cur_row;
    end

    s1_next.pixel     = pixel;
    s1_next.row       = cur_row;
    s1_next.col       = cur_col;
    s1_next.has_top   = (cur_row != '0);
    s1_next.has_right = (col_inc < w_eff);
    s1_next.last_row  = (row_inc == h_eff);
  end

  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // The reads see the previous row: the write to the same column in this
  // cycle lands after the read, and the right column is not rewritten yet.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      line_mem[cur_col] <= pixel;
      up_q              <= line_mem[cur_col];
      right_q           <= line_mem[col_inc[COL_W-1:0]];
    end
  end

  always_comb begin
    diff_right = (up_q >= right_q) ? (up_q - right_q) : (right_q - up_q);
    diff_down  = (up_q >= s1.pixel) ? (up_q - s1.pixel) : (s1.pixel - up_q);
    grad       = THRESH_W'(diff_right) + THRESH_W'(diff_down);
    if (s1.has_right) begin
      top_value = (grad >= threshold) ? EDGE_VALUE : FLAT_VALUE;
    end else begin
      top_value = up_q;
    end

    // The result for the row above goes first; a last-row pixel follows.
    emit_top   = s1.has_top && !s1_second;
    has_result = s1.has_top || s1.last_row;
    res_value  = emit_top ? top_value : s1.pixel;
    res_row    = emit_top ? (s1.row - ROW_W'(1)) : s1.row;
    res_last   = emit_top ? !s1.last_row : 1'b1;

    out_free = !out_valid || !out_stall;
    s1_emit  = s1_valid && has_result && out_free;
    s1_done  = s1_valid && (!has_result || (out_free && res_last));
  end

  assign in_stall = s1_valid && !s1_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s1_second <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid  <= 1'b1;
        s1_second <= 1'b0;
      end else begin
        if (s1_done) begin
          s1_valid <= 1'b0;
        end
        if (s1_emit && !res_last) begin
          s1_second <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1 <= s1_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_emit) begin
      value       <= res_value;
      out_row     <= res_row;
      out_col     <= s1.col;
      last_of_run <= res_last;
    end
  end

endmodule

`default_nettype wire

>>> src/det_checker.sv
// Port-level checks for the difference edge threshold block, with its bind.
`default_nettype none

module det_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [7:0]                     value,
  input wire logic [det_pkg::ROW_W-1:0]      out_row,
  input wire logic [det_pkg::COL_W-1:0]      out_col,
  input wire logic                           last_of_run,
  input wire logic                           cfg_valid,
  input wire logic                           cfg_ready
);
  import det_pkg::*;

  // Nothing is left on the output after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value) && $stable(out_row)
      && $stable(out_col) && $stable(last_of_run))
    else $error("stalled result changed");

  // The second result of a last-row pixel follows right behind the first,
  // one row lower in the same column.
  a_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_run |=> out_valid && last_of_run
      && (out_row == $past(out_row) + ROW_W'(1)) && $stable(out_col))
    else $error("second result of a pair missing or misplaced");

  // Register writes are never held off.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write blocked");

endmodule

bind difference_edge_threshold det_checker u_det_checker (.*);

`default_nettype wire

>>> tb/difference_edge_threshold_tb.sv
// Self-checking testbench for the difference edge threshold block.
`timescale 1ns / 1ps

module difference_edge_threshold_tb;
  import det_pkg::*;

  // Cycles to wait after the last expected result. Row 0 pixels cause no
  // result and may still be in the pipe, so this covers the block latency.
  localparam int DRAIN_CYCLES   = 12;
  // Cycles with no beat on any channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // Length of the long receiver hold-off that backs up the pipeline.
  localparam int LONG_HOLD      = 120;
  // Approximate number of random pixels, on top of the directed frames.
  localparam int RANDOM_PIXELS  = 1320;
  // Pixels of the first row sent in the saturated frame.
  localparam int BIG_FRAME_PIXELS = 64;

  typedef enum int {STYLE_UNIFORM, STYLE_SMOOTH, STYLE_BINARY} pix_style_t;

  // One expected result beat.
  typedef struct packed {
    logic [7:0]       value;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } edge_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       pixel = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       value;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic             last_of_run;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  cfg_idx_t         cfg_index = CFG_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  difference_edge_threshold i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel       (pixel),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .value       (value),
    .out_row     (out_row),
    .out_col     (out_col),
    .last_of_run (last_of_run),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // Pixels waiting to be offered, filled by the stimulus process.
  logic [7:0]   pixels_to_send[$];
  // Results the edge predictor has computed but the block has not yet sent.
  edge_result_t edge_results_due[$];

  // Shadow copy of the registers, the line store and the raster position.
  logic [8:0]  edge_thr    = '0;
  logic [11:0] frame_w_reg = 12'd640;
  logic [12:0] frame_h_reg = 13'd480;
  logic [7:0]  line_buf[MAX_WIDTH];
  int          row_pos = 0;
  int          col_pos = 0;

  int   mismatches    = 0;
  int   stuck_cycles  = 0;
  logic in_beat_done  = 1'b0;
  // Idling controls shared with the driver and the receiver.
  logic idling_on     = 1'b1;
  logic no_idling     = 1'b0;
  int   hold_requests = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Zero and oversize dimensions behave like the nearest legal value.
  function automatic int eff_width(input logic [11:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_WIDTH) return MAX_WIDTH;
    return int'(raw);
  endfunction

  function automatic int eff_height(input logic [12:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_HEIGHT) return MAX_HEIGHT;
    return int'(raw);
  endfunction

  function automatic int pixel_dist(input int a, input int b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Edge predictor: takes one accepted pixel and queues the results it causes.
  // The pixel above is resolved once its lower neighbor arrives; pixels of the
  // last row also emit themselves.
  task automatic apply_edge_pixel(input logic [7:0] px);
    int           w;
    int           h;
    int           up;
    int           grad;
    edge_result_t r;
    w = eff_width(frame_w_reg);
    h = eff_height(frame_h_reg);
    // A register write that shrank the frame under the counters restarts it.
    if (col_pos >= w || row_pos >= h) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (row_pos > 0) begin
      up = int'(line_buf[col_pos]);
      if (col_pos + 1 < w) begin
        grad = pixel_dist(up, int'(line_buf[col_pos + 1])) + pixel_dist(up, int'(px));
        r.value = (grad >= edge_thr) ? EDGE_VALUE : FLAT_VALUE;
      end else begin
        // The last column has no right neighbor and passes through.
        r.value = up[7:0];
      end
      r.row  = ROW_W'(row_pos - 1);
      r.col  = COL_W'(col_pos);
      r.last = (row_pos + 1 != h);
      edge_results_due.push_back(r);
    end
    if (row_pos + 1 == h) begin
      r.value = px;
      r.row   = ROW_W'(row_pos);
      r.col   = COL_W'(col_pos);
      r.last  = 1'b1;
      edge_results_due.push_back(r);
    end
    line_buf[col_pos] = px;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // Input driver. A beat that is offered stays put until it is taken; between
  // beats the sender may idle for bursts of random length.
  always @(negedge clk) begin : pixel_driver
    int gap_left;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else if (in_valid && !in_beat_done) begin
      // Still waiting for the block to take the current beat.
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (!no_idling && idling_on && pixels_to_send.size() != 0 &&
                 $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      gap_left = $urandom_range(0, 2);
    end else if (pixels_to_send.size() != 0) begin
      in_valid <= 1'b1;
      pixel    <= pixels_to_send.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result receiver. Besides short stall bursts it serves requests for one
  // long hold-off, during which the sender keeps offering pixels so that the
  // block fills up and has to stall its input.
  always @(negedge clk) begin : result_receiver
    int hold_left;
    int hold_served;
    int stall_left;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left   = 0;
      hold_served = 0;
      stall_left  = 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_served != hold_requests) begin
      out_stall <= 1'b1;
      hold_served++;
      hold_left = LONG_HOLD - 1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (!no_idling && idling_on && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: runs the predictor on every accepted pixel, checks every
  // accepted result against the oldest expectation, and guards against hangs.
  always @(posedge clk) begin : beat_monitor
    edge_result_t due;
    logic         any_beat;
    in_beat_done <= !rst && in_valid && !in_stall;
    if (!rst) begin
      any_beat = 1'b0;
      if (in_valid && in_stall === 1'b0) begin
        apply_edge_pixel(pixel);
        any_beat = 1'b1;
      end
      if (out_valid === 1'b1 && !out_stall) begin
        any_beat = 1'b1;
        if (edge_results_due.size() == 0) begin
          $error("unexpected result beat: value %0d row %0d col %0d",
                 value, out_row, out_col);
          mismatches++;
        end else begin
          due = edge_results_due.pop_front();
          if (value !== due.value) begin
            $error("value: expected %0d, got %0d", due.value, value);
            mismatches++;
          end
          if (out_row !== due.row) begin
            $error("out_row: expected %0d, got %0d", due.row, out_row);
            mismatches++;
          end
          if (out_col !== due.col) begin
            $error("out_col: expected %0d, got %0d", due.col, out_col);
            mismatches++;
          end
          if (last_of_run !== due.last) begin
            $error("last_of_run: expected %0d, got %0d", due.last, last_of_run);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready === 1'b1) any_beat = 1'b1;
      stuck_cycles = any_beat ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Waits until every pixel is taken and every expected result has arrived,
  // then lets the pipeline drain, so that registers can be written safely.
  task automatic wait_idle();
    do @(posedge clk);
    while (pixels_to_send.size() != 0 || in_valid || edge_results_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk);
    while (cfg_ready !== 1'b1);
    // Bits above each register's width are dropped.
    case (idx)
      CFG_THRESHOLD:    edge_thr    = data[THRESH_W-1:0];
      CFG_FRAME_WIDTH:  frame_w_reg = data[FWIDTH_W-1:0];
      CFG_FRAME_HEIGHT: frame_h_reg = data[FHEIGHT_W-1:0];
      default: ;
    endcase
  endtask

  // Writes all three registers, then queues a run of generated pixels.
  task automatic run_phase(input logic [CFG_DATA_W-1:0] thr_raw,
                           input logic [CFG_DATA_W-1:0] w_raw,
                           input logic [CFG_DATA_W-1:0] h_raw,
                           input int count, input pix_style_t style);
    int level;
    write_reg(CFG_THRESHOLD, thr_raw);
    write_reg(CFG_FRAME_WIDTH, w_raw);
    write_reg(CFG_FRAME_HEIGHT, h_raw);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    level = $urandom_range(0, 255);
    for (int k = 0; k < count; k++) begin
      case (style)
        STYLE_SMOOTH: begin
          // Small steps keep the gradient near typical thresholds.
          level = level + $urandom_range(0, 24) - 12;
          if (level < 0) level = 0;
          if (level > 255) level = 255;
          pixels_to_send.push_back(level[7:0]);
        end
        STYLE_BINARY: pixels_to_send.push_back($urandom_range(0, 1) ? 8'd255 : 8'd0);
        default:      pixels_to_send.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  initial begin : stimulus
    int          sent;
    int          phase_no;
    int          cur_w;
    int          nw;
    int          nh;
    int          start_row;
    int          start_col;
    int          remaining;
    int          count;
    logic        restart;
    logic [8:0]  thr;
    logic [11:0] fw;
    logic [12:0] fh;
    pix_style_t  style;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // 4 by 3 frame with threshold 0: every interior pixel is an edge. The
    // threshold write carries junk above bit 8 and the width write above bit
    // 11, which the registers must drop. Pixel values hit both extremes.
    run_phase(13'h1E00, 13'h1004, 13'd3, 0, STYLE_UNIFORM);
    pixels_to_send = {8'd0, 8'd255, 8'd0, 8'd255,
                      8'd255, 8'd0, 8'd128, 8'd1,
                      8'd0, 8'd0, 8'd255, 8'd255};
    // Zero width and height act as a single pixel frame: everything passes
    // through. The highest threshold never flags an edge.
    wait_idle();
    run_phase(13'd511, 13'd0, 13'd0, 0, STYLE_UNIFORM);
    pixels_to_send = {8'd0, 8'd255, 8'd170};
    // Two 2 by 2 frames: the first has a gradient equal to the threshold
    // (an edge), the second one just below it (flat).
    wait_idle();
    run_phase(13'd10, 13'd2, 13'd2, 0, STYLE_UNIFORM);
    pixels_to_send = {8'd100, 8'd105, 8'd95, 8'd7,
                      8'd100, 8'd104, 8'd95, 8'd7};

    // Largest frame: width and height both saturate. A stretch of the first
    // row goes in, which only fills the line store.
    wait_idle();
    run_phase(13'd300, 13'h0FFF, 13'h1FFF, BIG_FRAME_PIXELS, STYLE_UNIFORM);
    // Width written as zero while in the middle of the big frame: the column
    // counter falls outside and the frame restarts at the top.
    wait_idle();
    run_phase(13'd20, 13'd0, 13'h1FFF, 40, STYLE_SMOOTH);

    sent     = 0;
    phase_no = 0;
    while (sent < RANDOM_PIXELS) begin
      wait_idle();
      // The tail of the run goes at full rate on both sides.
      no_idling = (sent > RANDOM_PIXELS - 200);
      idling_on = ($urandom_range(0, 3) != 0);
      style     = pix_style_t'($urandom_range(0, 2));

      case ($urandom_range(0, 7))
        0:       thr = 9'd0;
        1:       thr = 9'd511;
        2:       thr = 9'($urandom_range(0, 511));
        default: thr = 9'($urandom_range(0, 60));
      endcase
      case ($urandom_range(0, 9))
        0:       fw = 12'd0;
        default: fw = 12'($urandom_range(1, 8));
      endcase
      fh = ($urandom_range(0, 9) == 0) ? 13'd0 : 13'($urandom_range(1, 6));
      if (phase_no == 8) begin
        fw = 12'd8;
        fh = 13'd20;
      end

      // Widening the frame in the middle of it would read line store entries
      // that the previous row never wrote, so the width is held instead.
      cur_w   = eff_width(frame_w_reg);
      nw      = eff_width(fw);
      nh      = eff_height(fh);
      restart = (col_pos >= nw || row_pos >= nh);
      if (row_pos > 0 && !restart && nw > cur_w) begin
        fw = 12'(cur_w);
        nw = cur_w;
      end
      start_row = restart ? 0 : row_pos;
      start_col = restart ? 0 : col_pos;
      remaining = (nh - start_row) * nw - start_col;

      // Mostly finish the frame, sometimes with one more whole frame; now and
      // then stop in the middle so the next phase changes sizes under it.
      if (phase_no == 8) count = remaining + nw * nh;
      else if ($urandom_range(0, 9) < 7)
        count = remaining + ($urandom_range(0, 1) ? nw * nh : 0);
      else count = $urandom_range(1, remaining + nw);

      run_phase({4'($urandom_range(0, 15)), thr}, {1'($urandom_range(0, 1)), fw}, fh,
                count, style);
      // The pressure phase: the receiver holds off while pixels keep coming.
      if (phase_no == 8) hold_requests++;
      sent += count;
      phase_no++;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
